[rtl/core/qdcr_pkg.sv]
// ----------------------------------------------------------------------------
// qdcr_pkg
// Shared types and codes of the quantized dense layer with clipped relu.
// ----------------------------------------------------------------------------
package qdcr_pkg;

  // item action codes
  localparam logic [1:0] ACT_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_BIAS   = 2'd1;
  localparam logic [1:0] ACT_VECTOR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INPUTS  = 2'd0;
  localparam logic [1:0] CFG_OUTPUTS = 2'd1;
  localparam logic [1:0] CFG_DIVISOR = 2'd2;

  // clip ceiling of the result
  localparam logic [6:0] CLIP_MAX = 7'd127;

  // store writes routed to one neuron cell
  typedef struct packed {
    logic               wr_weight;
    logic               wr_bias;
    logic [8:0]         col;
    logic signed [7:0]  weight;
    logic signed [31:0] bias;
  } load_t;

  // activation handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic signed [15:0] act;
  } flow_t;

  // result tag carried through the divider
  typedef struct packed {
    logic       last;
    logic [4:0] index;
  } tag_t;

endpackage

[rtl/core/qdcr_cell.sv]
// ----------------------------------------------------------------------------
// qdcr_cell
// One neuron: weight row, bias, multiply-accumulate and drain shift stage.
// ----------------------------------------------------------------------------
module qdcr_cell #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned ADDR_W = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  qdcr_pkg::load_t     load,
  input  logic                clear,
  input  logic                shift,
  input  qdcr_pkg::flow_t     flow_in,
  input  logic [ADDR_W-1:0]   idx_in,
  input  logic [31:0]         acc_in,
  output qdcr_pkg::flow_t     flow_out,
  output logic [ADDR_W-1:0]   idx_out,
  output logic [31:0]         acc_out
);
  import qdcr_pkg::*;

  logic signed [7:0]  wmem [0:DEPTH-1];
  logic signed [7:0]  w_q;
  logic signed [31:0] bias;
  flow_t              stage_a;
  logic [ADDR_W-1:0]  idx_a;
  logic signed [23:0] prod;
  logic               prod_valid;
  logic [31:0]        acc;

  // weight row store
  always_ff @(posedge clk) begin
    if (load.wr_weight) begin
      wmem[ADDR_W'(load.col)] <= load.weight;
    end
    w_q <= wmem[idx_in];
  end

  // bias register
  always_ff @(posedge clk) begin
    if (load.wr_bias) begin
      bias <= load.bias;
    end
  end

  // hand activation on to the neighbour
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_a.valid <= 1'b0;
    end else begin
      stage_a.valid <= flow_in.valid;
    end
    stage_a.act <= flow_in.act;
    idx_a       <= idx_in;
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= stage_a.valid;
    end
    prod <= 24'(stage_a.act * w_q);
  end

  // accumulator: bias load, drain shift or accumulate
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= bias;
    end else if (shift) begin
      acc <= acc_in;
    end else if (prod_valid) begin
      acc <= acc + {{8{prod[23]}}, prod};
    end
  end

  assign flow_out = stage_a;
  assign idx_out  = idx_a;
  assign acc_out  = acc;

endmodule

[rtl/core/qdcr_div.sv]
// ----------------------------------------------------------------------------
// qdcr_div
// Sequential divide of a neuron sum with clip to 0..127, one bit per cycle.
// ----------------------------------------------------------------------------
module qdcr_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  sum,
  input  logic [15:0]         divisor,
  input  qdcr_pkg::tag_t      tag_in,
  input  logic                take,
  output logic                ready,
  output logic                res_valid,
  output logic [6:0]          res_value,
  output qdcr_pkg::tag_t      res_tag
);
  import qdcr_pkg::*;

  logic        busy;
  logic [2:0]  steps;
  logic [22:0] rem;
  logic [22:0] dv;
  logic [6:0]  quo;
  logic [31:0] limit;
  logic        rem_ge;

  assign limit  = {9'd0, divisor, 7'd0};
  assign rem_ge = (rem >= dv);
  assign ready  = !busy && !res_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      steps     <= 3'd0;
    end else if (start) begin
      if (sum[31] || ({1'b0, sum[30:0]} >= limit)) begin
        res_valid <= 1'b1;
      end else begin
        busy  <= 1'b1;
        steps <= 3'd6;
      end
    end else if (busy) begin
      steps <= steps - 3'd1;
      if (steps == 3'd0) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  // datapath: restoring division over seven quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      res_tag <= tag_in;
      rem     <= sum[22:0];
      dv      <= {1'b0, divisor, 6'd0};
      if (sum[31]) begin
        res_value <= 7'd0;
      end else begin
        res_value <= CLIP_MAX;
      end
      quo <= 7'd0;
    end else if (busy) begin
      dv <= dv >> 1;
      if (rem_ge) begin
        rem <= rem - dv;
      end
      quo <= {quo[5:0], rem_ge};
      if (steps == 3'd0) begin
        res_value <= {quo[5:0], rem_ge};
      end
    end
  end

endmodule

[rtl/core/quantized_dense_clipped_relu.sv]
// ----------------------------------------------------------------------------
// quantized_dense_clipped_relu
// Quantized dense layer: weight and bias loads, activation vector, clipped out.
// ----------------------------------------------------------------------------
// Usage
//   Items enter on item_valid / item_stall. Weight and bias loads go straight
//   into the addressed cell. Activations are stored in order; the one that
//   completes the vector starts a run and item_stall stays high until the
//   last neuron sum has been handed to the divider.
//   A run sweeps the stored activations through a chain of MAX_OUT neuron
//   cells, one activation per cycle. The sums then shift out of cell 0 into
//   one shared divider, which clips a negative or too large sum without
//   dividing and divides the others bit by bit; it takes a new sum only
//   once its last result has been handed on.
//   Results leave on result_valid / result_stall through an output register;
//   the divider holds its result while the receiver stalls, and the drain
//   waits on the divider. New items are taken while the last results wait.
//   Configuration writes on cfg_valid / cfg_ready are always taken and must
//   only come while no run is in flight.
//   Reset (rst, synchronous) clears the activation count and control state
//   and sets inputs 512, outputs 32, divisor 64; stores need writing first.
// ----------------------------------------------------------------------------
module quantized_dense_clipped_relu #(
  parameter int unsigned MAX_OUT = 32,
  parameter int unsigned MAX_IN  = 512
) (
  input  logic                clk,
  input  logic                rst,
  // item channel
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          action,
  input  logic [4:0]          row_index,
  input  logic [8:0]          col_index,
  input  logic signed [7:0]   weight_value,
  input  logic signed [31:0]  bias_value,
  input  logic signed [15:0]  activation,
  // result channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [4:0]          out_index,
  output logic [6:0]          out_value,
  output logic                last_of_run,
  // configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import qdcr_pkg::*;

  localparam int unsigned AW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int unsigned TW = $clog2(MAX_IN + MAX_OUT + 8);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]         state;
  logic [9:0]         active_inputs;
  logic [5:0]         active_outputs;
  logic [15:0]        scale_divisor;
  logic [9:0]         act_count;
  logic [9:0]         count_inc;
  logic [9:0]         n_in;
  logic [5:0]         n_out;
  logic [15:0]        div_eff;
  logic [TW-1:0]      tmr;
  logic [5:0]         drain_row;
  logic               item_take;
  logic               vec_done;
  logic               run_clear;
  logic               drain_shift;

  logic signed [15:0] amem [0:MAX_IN-1];
  logic signed [15:0] act_rd;
  logic               rd_valid;
  logic [AW-1:0]      rd_idx;

  load_t              ld      [0:MAX_OUT-1];
  flow_t              flow_c  [0:MAX_OUT];
  logic [AW-1:0]      idx_c   [0:MAX_OUT];
  logic [31:0]        acc_c   [0:MAX_OUT];

  logic               div_ready;
  logic               div_res_valid;
  logic [6:0]         div_res_value;
  tag_t               div_res_tag;
  tag_t               drain_tag;
  logic               div_take;

  // effective sizes
  always_comb begin
    if (active_inputs == 10'd0) begin
      n_in = 10'd1;
    end else if (32'(active_inputs) > MAX_IN) begin
      n_in = 10'(MAX_IN);
    end else begin
      n_in = active_inputs;
    end
    if (active_outputs == 6'd0) begin
      n_out = 6'd1;
    end else if (32'(active_outputs) > MAX_OUT) begin
      n_out = 6'(MAX_OUT);
    end else begin
      n_out = active_outputs;
    end
    div_eff = (scale_divisor == 16'd0) ? 16'd1 : scale_divisor;
  end

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_inputs  <= 10'd512;
      active_outputs <= 6'd32;
      scale_divisor  <= 16'd64;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INPUTS:  active_inputs  <= cfg_data[9:0];
        CFG_OUTPUTS: active_outputs <= cfg_data[5:0];
        CFG_DIVISOR: scale_divisor  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // item handshake and vector completion
  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign count_inc  = act_count + 10'd1;
  assign vec_done   = item_take && (action == ACT_VECTOR) &&
                      ((count_inc >= n_in) || (count_inc == 10'd0));
  assign run_clear  = vec_done;

  // activation store
  always_ff @(posedge clk) begin
    if (item_take && (action == ACT_VECTOR) && (32'(act_count) < MAX_IN)) begin
      amem[AW'(act_count)] <= activation;
    end
    act_rd <= amem[AW'(tmr)];
    rd_idx <= AW'(tmr);
  end

  // sequencer
  assign drain_shift = (state == S_DRAIN) && div_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      act_count <= 10'd0;
      tmr       <= '0;
      drain_row <= 6'd0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= (state == S_MAC) && (32'(tmr) < 32'(n_in));
      unique case (state)
        S_IDLE: begin
          if (item_take && (action == ACT_VECTOR)) begin
            act_count <= vec_done ? 10'd0 : count_inc;
          end
          if (vec_done) begin
            state <= S_MAC;
            tmr   <= '0;
          end
        end
        S_MAC: begin
          tmr <= tmr + TW'(1);
          if (tmr == TW'(n_in) + TW'(MAX_OUT + 3)) begin
            state     <= S_DRAIN;
            drain_row <= 6'd0;
          end
        end
        S_DRAIN: begin
          if (drain_shift) begin
            drain_row <= drain_row + 6'd1;
            if (drain_row + 6'd1 == n_out) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // chain of neuron cells
  assign flow_c[0].valid = rd_valid;
  assign flow_c[0].act   = act_rd;
  assign idx_c[0]        = rd_idx;
  assign acc_c[MAX_OUT]  = 32'd0;

  for (genvar k = 0; k < MAX_OUT; k++) begin : g_cell
    assign ld[k] = '{
      wr_weight: item_take && (action == ACT_WEIGHT) &&
                 (32'(row_index) == k) && (32'(col_index) < MAX_IN),
      wr_bias:   item_take && (action == ACT_BIAS) && (32'(row_index) == k),
      col:       col_index,
      weight:    weight_value,
      bias:      bias_value
    };

    qdcr_cell #(
      .DEPTH  (MAX_IN),
      .ADDR_W (AW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (ld[k]),
      .clear    (run_clear),
      .shift    (drain_shift),
      .flow_in  (flow_c[k]),
      .idx_in   (idx_c[k]),
      .acc_in   (acc_c[k+1]),
      .flow_out (flow_c[k+1]),
      .idx_out  (idx_c[k+1]),
      .acc_out  (acc_c[k])
    );
  end

  // shared divider
  assign drain_tag.index = drain_row[4:0];
  assign drain_tag.last  = (drain_row + 6'd1 == n_out);
  assign div_take        = div_res_valid && (!result_valid || !result_stall);

  qdcr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (drain_shift),
    .sum       (acc_c[0]),
    .divisor   (div_eff),
    .tag_in    (drain_tag),
    .take      (div_take),
    .ready     (div_ready),
    .res_valid (div_res_valid),
    .res_value (div_res_value),
    .res_tag   (div_res_tag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (div_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_index   <= div_res_tag.index;
      out_value   <= div_res_value;
      last_of_run <= div_res_tag.last;
    end
  end

endmodule
